[design/gsig_pkg.sv]
package gsig_pkg;

    localparam int INDEX_WIDTH = 16;
    localparam int PATCH_W     = 8;
    localparam int CACHE_W     = 10;
    // Rows and columns need one bit more than the patch size so that a grid side of 257 fits.
    localparam int COORD_W     = PATCH_W + 1;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_PATCH_SIZE        = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_CACHE_SIZE = CFG_INDEX_W'(1);

    localparam logic [PATCH_W-1:0] PATCH_SIZE_RESET        = PATCH_W'(17);
    localparam logic [CACHE_W-1:0] VERTEX_CACHE_SIZE_RESET = CACHE_W'(24);

    typedef struct packed {
        logic [PATCH_W-1:0] patch_size;
        logic [CACHE_W-1:0] vertex_cache_size;
    } t_grid_cfg;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] vertex_index;
        logic                   last_index;
    } t_step_result;

    // Grid side D = patch size plus the two skirt vertices.
    function automatic logic [COORD_W-1:0] grid_side(input logic [PATCH_W-1:0] patch);
        return COORD_W'(patch) + COORD_W'(2);
    endfunction

    // Band height in row steps: half the cache minus one, at least one.
    function automatic logic [COORD_W-1:0] band_step(input logic [CACHE_W-1:0] cache);
        logic [CACHE_W-2:0] half;
        half = cache[CACHE_W-1:1];
        if (half < (CACHE_W-1)'(2)) begin
            return COORD_W'(1);
        end
        return COORD_W'(half - (CACHE_W-1)'(1));
    endfunction

    // End row of a band that starts at row start, clamped to the last grid row.
    function automatic logic [COORD_W-1:0] clamp_end(input logic [COORD_W-1:0] start,
                                                     input t_grid_cfg cfg);
        logic [COORD_W:0]   e;
        logic [COORD_W-1:0] last;
        last = COORD_W'(cfg.patch_size) + COORD_W'(1);
        e    = (COORD_W+1)'(start) + (COORD_W+1)'(band_step(cfg.vertex_cache_size));
        if (e > (COORD_W+1)'(last)) begin
            return last;
        end
        return e[COORD_W-1:0];
    endfunction

endpackage

[design/grid_strip_index_generator.sv]
// Channel   Direction  Word                              Handshake
// s_axis    in         tdata[0] = restart                i_s_axis_tvalid / o_s_axis_tready
// m_axis    out        tdata = vertex_index, tlast = last o_m_axis_tvalid / i_m_axis_tready
// cfg       in         index 0 patch_size, 1 cache size  i_cfg_valid / o_cfg_ready
//
// Each accepted input word produces exactly one output word in the next cycle.
// The throughput is one word per cycle: the strip counters and the single 9x9
// multiplier that forms row offset times grid side sit between the input handshake
// and the output register, and the output register accepts a new word whenever it
// is empty or being drained in the same cycle.
// Reset is synchronous and active low; it restores the register defaults and arms
// a restart, as does every write to a listed register. The configuration port is
// always ready.
// A stall on the output side holds the output word and drops o_s_axis_tready.
module grid_strip_index_generator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input word, bit 0: restart; bits 7:1 are zero.
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [gsig_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // Output word, bits 15:0: vertex_index. tlast carries last_index.
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [gsig_pkg::INDEX_WIDTH-1:0]     o_m_axis_tdata,
    output logic                                 o_m_axis_tlast,
    // Register write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [gsig_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [gsig_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import gsig_pkg::*;

    t_grid_cfg    r_cfg;
    logic         r_out_valid;
    t_step_result r_out;
    t_step_result step_result;
    logic         in_accept;
    logic         cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid & o_cfg_ready;

    // The output register takes a new word when it is empty or being emptied now.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid & o_s_axis_tready;

    // Register file. Writes to indexes beyond the list are accepted and ignored,
    // and they leave the strip position alone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.patch_size        <= PATCH_SIZE_RESET;
            r_cfg.vertex_cache_size <= VERTEX_CACHE_SIZE_RESET;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                REG_PATCH_SIZE: begin
                    r_cfg.patch_size <= i_cfg_data[PATCH_W-1:0];
                end
                REG_VERTEX_CACHE_SIZE: begin
                    r_cfg.vertex_cache_size <= i_cfg_data[CACHE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A write to an unlisted index leaves the sequence alone.
    gsig_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (in_accept),
        .i_restart   (i_s_axis_tdata[0]),
        .i_cfg_write (cfg_write && (i_cfg_index == REG_PATCH_SIZE ||
                                    i_cfg_index == REG_VERTEX_CACHE_SIZE)),
        .i_cfg       (r_cfg),
        .o_result    (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= step_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.vertex_index;
    assign o_m_axis_tlast  = r_out.last_index;

endmodule

[design/gsig_core.sv]
module gsig_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic                  i_restart,
    input  logic                  i_cfg_write,
    input  gsig_pkg::t_grid_cfg   i_cfg,
    output gsig_pkg::t_step_result o_result
);
    import gsig_pkg::*;

    typedef enum logic [3:0] {
        PH_FIRST  = 4'b0001,
        PH_SECOND = 4'b0010,
        PH_DEG_A  = 4'b0100,
        PH_DEG_B  = 4'b1000
    } t_phase;

    logic               r_pending;
    logic [COORD_W-1:0] r_start, r_end, r_col, r_row;
    t_phase             r_phase;

    logic [COORD_W-1:0] n_start, n_end, n_col, n_row;
    t_phase             n_phase;

    logic               restart;
    logic [COORD_W-1:0] cur_start, cur_end, cur_col, cur_row;
    t_phase             cur_phase;

    logic [COORD_W-1:0]   side, last_row, col_inc, sel_row, add_col, row_off;
    logic [2*COORD_W-1:0] prod;
    logic [2*COORD_W:0]   sum;
    logic                 col_last, flag;

    // A pending restart is raised by reset and by every write on i_cfg_write, so the first
    // item after either starts the strip from the top with the current register values.
    assign restart = i_restart | r_pending;

    always_comb begin
        if (restart) begin
            cur_start = '0;
            cur_end   = clamp_end('0, i_cfg);
            cur_col   = '0;
            cur_row   = '0;
            cur_phase = PH_FIRST;
        end else begin
            cur_start = r_start;
            cur_end   = r_end;
            cur_col   = r_col;
            cur_row   = r_row;
            cur_phase = r_phase;
        end
    end

    assign side     = grid_side(i_cfg.patch_size);
    assign last_row = COORD_W'(i_cfg.patch_size) + COORD_W'(1);
    assign col_inc  = cur_col + COORD_W'(1);
    // Column plus two reaching the side is the same as column reaching the patch size.
    assign col_last = (cur_col >= COORD_W'(i_cfg.patch_size));

    always_comb begin
        n_start = cur_start;
        n_end   = cur_end;
        n_col   = cur_col;
        n_row   = cur_row;
        n_phase = cur_phase;
        sel_row = cur_row;
        add_col = cur_col;
        flag    = 1'b0;
        unique case (cur_phase)
            PH_FIRST: begin
                n_phase = PH_SECOND;
            end
            PH_SECOND: begin
                add_col = col_inc;
                if (cur_row >= cur_end) begin
                    if ((cur_end >= last_row) && col_last) begin
                        flag    = 1'b1;
                        n_start = '0;
                        n_end   = clamp_end('0, i_cfg);
                        n_col   = '0;
                        n_row   = '0;
                        n_phase = PH_FIRST;
                    end else begin
                        n_phase = PH_DEG_A;
                    end
                end else begin
                    n_row   = cur_row + COORD_W'(1);
                    n_phase = PH_FIRST;
                end
            end
            PH_DEG_A: begin
                sel_row = cur_end;
                add_col = col_inc;
                n_phase = PH_DEG_B;
            end
            PH_DEG_B: begin
                if (col_last) begin
                    sel_row = cur_end;
                    add_col = '0;
                    n_start = cur_end;
                    n_end   = clamp_end(cur_end, i_cfg);
                    n_col   = '0;
                    n_row   = cur_end;
                end else begin
                    sel_row = cur_start;
                    add_col = col_inc;
                    n_col   = col_inc;
                    n_row   = cur_start;
                end
                n_phase = PH_FIRST;
            end
            default: begin
                n_phase = PH_FIRST;
            end
        endcase
    end

    // Rows count from the bottom of the grid: index = (last row - row) * side + column.
    assign row_off = last_row - sel_row;
    assign prod    = row_off * side;
    assign sum     = (2*COORD_W+1)'(prod) + (2*COORD_W+1)'(add_col);

    assign o_result.vertex_index = sum[INDEX_WIDTH-1:0];
    assign o_result.last_index   = flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b1;
            r_start   <= '0;
            r_end     <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_phase   <= PH_FIRST;
        end else if (i_cfg_write) begin
            r_pending <= 1'b1;
        end else if (i_advance) begin
            r_pending <= 1'b0;
            r_start   <= n_start;
            r_end     <= n_end;
            r_col     <= n_col;
            r_row     <= n_row;
            r_phase   <= n_phase;
        end
    end

endmodule

[design/gsig_checker.sv]
module gsig_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic [gsig_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [gsig_pkg::INDEX_WIDTH-1:0]  o_m_axis_tdata,
    input logic                              o_m_axis_tlast,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready
);

    // Every accepted input word shows up at the output on the next cycle.
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> o_m_axis_tvalid)
        else $error("accepted word did not reach the output register");

    // A stalled output word must block new input.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while output stalled");

    // A stalled output word holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("stalled output word changed");

    // The first index after a restart is never the last one of the strip.
    a_restart_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tdata[0]) |=> !o_m_axis_tlast)
        else $error("restart word flagged as last");

    // The register port never stalls.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind grid_strip_index_generator gsig_checker u_gsig_checker (.*);

[verif/grid_strip_index_checker.sv]
module grid_strip_index_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    input  logic                              i_s_axis_tready,
    input  logic [gsig_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    input  logic                              i_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [gsig_pkg::INDEX_WIDTH-1:0]  i_m_axis_tdata,
    input  logic                              i_m_axis_tlast,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [gsig_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [gsig_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int unsigned                       o_fail_count,
    output int unsigned                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import gsig_pkg::*;

    localparam int unsigned PRINT_LIMIT = 40;

    // Pair of strip indices per row, then the two degenerate joining indices.
    typedef enum logic [1:0] {
        PAIR_FIRST,
        PAIR_SECOND,
        JOIN_FIRST,
        JOIN_SECOND
    } t_emit_step;

    logic [PATCH_W-1:0] cur_patch;
    logic [CACHE_W-1:0] cur_cache;
    logic [COORD_W-1:0] band_first_row;
    logic [COORD_W-1:0] band_last_row;
    logic [COORD_W-1:0] strip_col;
    logic [COORD_W-1:0] strip_row;
    t_emit_step         emit_step;

    t_step_result pending_indices[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what);
        o_fail_count++;
        if (o_fail_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Last row of a band starting at the given row, clamped to the top grid row.
    function automatic logic [COORD_W-1:0] band_end_row(input logic [COORD_W-1:0] start);
        int unsigned top_row;
        int unsigned steps;
        int unsigned reach;
        top_row = int'(cur_patch) + 1;
        steps   = int'(cur_cache) / 2;
        steps   = (steps < 2) ? 1 : steps - 1;
        reach   = int'(start) + steps;
        return COORD_W'((reach > top_row) ? top_row : reach);
    endfunction

    function automatic void rewind_strip();
        band_first_row = '0;
        band_last_row  = band_end_row('0);
        strip_col      = '0;
        strip_row      = '0;
        emit_step      = PAIR_FIRST;
    endfunction

    function automatic t_step_result advance_strip(input logic restart);
        int unsigned  side;
        int unsigned  top_row;
        int unsigned  idx;
        t_step_result res;
        side    = int'(cur_patch) + 2;
        top_row = side - 1;
        res     = '0;
        idx     = 0;
        if (restart) begin
            rewind_strip();
        end
        case (emit_step)
            PAIR_FIRST: begin
                idx       = (top_row - strip_row) * side + strip_col;
                emit_step = PAIR_SECOND;
            end
            PAIR_SECOND: begin
                idx = (top_row - strip_row) * side + strip_col + 1;
                if (strip_row >= band_last_row) begin
                    if (band_last_row >= top_row && strip_col + 2 >= side) begin
                        res.last_index = 1'b1;
                        rewind_strip();
                    end else begin
                        emit_step = JOIN_FIRST;
                    end
                end else begin
                    strip_row = strip_row + 1'b1;
                    emit_step = PAIR_FIRST;
                end
            end
            JOIN_FIRST: begin
                idx       = (top_row - band_last_row) * side + strip_col + 1;
                emit_step = JOIN_SECOND;
            end
            default: begin
                if (strip_col + 2 >= side) begin
                    // Last column of the band: jump back to column 0 of the next band.
                    idx            = (top_row - band_last_row) * side;
                    band_first_row = band_last_row;
                    band_last_row  = band_end_row(band_first_row);
                    strip_col      = '0;
                end else begin
                    idx       = (top_row - band_first_row) * side + strip_col + 1;
                    strip_col = strip_col + 1'b1;
                end
                strip_row = band_first_row;
                emit_step = PAIR_FIRST;
            end
        endcase
        res.vertex_index = idx[INDEX_WIDTH-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_step_result want;
        if (!i_rst_n) begin
            cur_patch = PATCH_SIZE_RESET;
            cur_cache = VERTEX_CACHE_SIZE_RESET;
            rewind_strip();
            pending_indices.delete();
        end else begin
            if ($isunknown({i_m_axis_tvalid, i_s_axis_tready, i_cfg_ready})) begin
                report_mismatch("handshake output is unknown");
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PATCH_SIZE: begin
                        cur_patch = i_cfg_data[PATCH_W-1:0];
                        rewind_strip();
                    end
                    REG_VERTEX_CACHE_SIZE: begin
                        cur_cache = i_cfg_data[CACHE_W-1:0];
                        rewind_strip();
                    end
                    default: ;
                endcase
            end
            // The output word of this edge stems from an earlier input word, so
            // compare before queueing the prediction for this edge's input.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_indices.size() == 0) begin
                    report_mismatch($sformatf("unexpected output word %0d", i_m_axis_tdata));
                end else begin
                    want = pending_indices.pop_front();
                    if (i_m_axis_tdata !== want.vertex_index) begin
                        report_mismatch($sformatf("vertex_index %0d, expected %0d",
                                                  i_m_axis_tdata, want.vertex_index));
                    end
                    if (i_m_axis_tlast !== want.last_index) begin
                        report_mismatch($sformatf("last_index %0b, expected %0b at index %0d",
                                                  i_m_axis_tlast, want.last_index,
                                                  want.vertex_index));
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                pending_indices = {pending_indices, advance_strip(i_s_axis_tdata[0])};
            end
        end
        o_pending = pending_indices.size();
    end

endmodule

[verif/grid_strip_index_generator_test.sv]
// Stimulus and verdict for the strip index generator. A checker sits beside the
// block, follows every handshake, predicts each output word and counts failures.
// This module only drives words, register writes and the output-side ready.
module grid_strip_index_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gsig_pkg::*;

    localparam int unsigned ITEM_TARGET = 1700;
    // Length of the one long output stall, long enough to back the block up.
    localparam int unsigned LONG_HOLD   = 80;
    // Any index past the register list must be ignored by the block.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST = '1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_DATA_W-1:0]   s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [INDEX_WIDTH-1:0] m_data;
    logic                   m_last;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int unsigned            fail_count;
    int unsigned            pending;

    // When set, neither side inserts random gaps between words.
    bit steady = 1'b1;
    // Set by the stimulus to ask the receiver for one long stall.
    bit long_hold_req = 1'b0;

    grid_strip_index_generator i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    grid_strip_index_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned draw_gap();
        return steady ? 0 : $urandom_range(0, 8);
    endfunction

    // Offers one input word and returns at the falling edge after it was taken.
    // Valid is only lowered when a gap is drawn, so back-to-back words keep it high.
    task automatic send_word(input logic restart);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= IN_DATA_W'(restart);
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Stops offering words and waits until every predicted word has come out,
    // which leaves the block idle for register writes.
    task automatic drain_words();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Output side: a fresh ready pattern for every word, plus one long stall
    // on request, during which the sender keeps pushing so that the block fills up.
    initial begin : receiver
        int unsigned hold;
        @(negedge clk);
        forever begin
            if (long_hold_req) begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end else begin
                hold = draw_gap();
            end
            if (hold != 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_ready <= 1'b1;
            @(posedge clk);
            while (!m_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        int unsigned        sent;
        int unsigned        phase_no;
        int unsigned        phase_len;
        int unsigned        pick;
        logic [PATCH_W-1:0] patch;
        logic [CACHE_W-1:0] cache;

        sent     = 0;
        phase_no = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register defaults straight out of reset, with a restart in the middle
        // of a strip.
        steady = 1'b1;
        repeat (3) send_word(1'b0);
        send_word(1'b1);
        repeat (2) send_word(1'b0);
        drain_words();

        // Smallest grid (single column, last index 1) with a cache too small
        // for a band, so the band height falls back to one row. Six words wrap
        // the four-word strip.
        write_reg(REG_PATCH_SIZE, '0);
        write_reg(REG_VERTEX_CACHE_SIZE, '0);
        repeat (6) send_word(1'b0);
        drain_words();

        // Largest grid side: indices wrap at the index width. Largest cache.
        steady = 1'b0;
        write_reg(REG_PATCH_SIZE, CFG_DATA_W'({PATCH_W{1'b1}}));
        write_reg(REG_VERTEX_CACHE_SIZE, CFG_DATA_W'({CACHE_W{1'b1}}));
        repeat (4) send_word(1'b0);
        send_word(1'b1);
        drain_words();

        // A write past the register list must neither change a register nor
        // restart the strip, so these words continue where the last ones stopped.
        write_reg(REG_UNUSED_LAST, '1);
        repeat (3) send_word(1'b0);
        drain_words();

        // Narrow grid with the smallest legal cache.
        write_reg(REG_PATCH_SIZE, CFG_DATA_W'(1));
        write_reg(REG_VERTEX_CACHE_SIZE, CFG_DATA_W'(4));
        repeat (5) send_word(1'b0);
        drain_words();

        // Random phases. The first few pin the register extremes; later ones
        // mostly use small grids so that whole strips, with their last index
        // and the wrap back to the start, are walked many times over.
        while (sent < ITEM_TARGET) begin
            case (phase_no)
                0: begin
                    patch = PATCH_W'(254);
                    cache = CACHE_W'(4);
                end
                1: begin
                    patch = PATCH_W'(1);
                    cache = CACHE_W'(512);
                end
                2: begin
                    patch = '1;
                    cache = CACHE_W'(2);
                end
                3: begin
                    patch = '0;
                    cache = '1;
                end
                default: begin
                    if ($urandom_range(0, 9) == 0) begin
                        patch = PATCH_W'($urandom_range(0, 255));
                        cache = CACHE_W'($urandom_range(0, 1023));
                    end else begin
                        patch = PATCH_W'($urandom_range(0, 3));
                        cache = CACHE_W'($urandom_range(0, 16));
                    end
                end
            endcase

            // Upper data bits beyond a register's width are random and must be dropped.
            pick = (phase_no < 4) ? 5 : $urandom_range(0, 5);
            case (pick)
                0: write_reg(CFG_INDEX_W'($urandom_range(REG_VERTEX_CACHE_SIZE + 1,
                                                         REG_UNUSED_LAST)),
                             CFG_DATA_W'($urandom()));
                1: write_reg(REG_PATCH_SIZE,
                             CFG_DATA_W'({$urandom_range(0, 255), patch}));
                2: write_reg(REG_VERTEX_CACHE_SIZE,
                             CFG_DATA_W'({$urandom_range(0, 63), cache}));
                3: begin
                    write_reg(REG_VERTEX_CACHE_SIZE, CFG_DATA_W'(cache));
                    write_reg(REG_PATCH_SIZE, CFG_DATA_W'(patch));
                end
                default: begin
                    write_reg(REG_PATCH_SIZE, CFG_DATA_W'(patch));
                    write_reg(REG_VERTEX_CACHE_SIZE, CFG_DATA_W'(cache));
                end
            endcase

            // Large grids never reach their last index in a sensible time, so
            // their phases stay short.
            phase_len = (patch > 16) ? $urandom_range(30, 60) : $urandom_range(50, 200);
            steady    = ($urandom_range(0, 3) == 0) || (phase_no == 4);
            for (int unsigned n = 0; n < phase_len; n++) begin
                // One long output stall while the sender keeps offering words.
                if (phase_no == 4 && n == 5) begin
                    long_hold_req = 1'b1;
                end
                send_word($urandom_range(0, 63) == 0);
                sent++;
            end
            drain_words();
            phase_no++;
        end

        // The block answers each word in the next cycle; the wait below also catches
        // anything spurious.
        repeat (4) @(negedge clk);
        if (fail_count == 0) begin
            $display("grid_strip_index_generator_test OK");
        end else begin
            $display("grid_strip_index_generator_test NOT OK");
        end
        $finish;
    end

    // Far beyond the slowest correct run: every word with the widest gaps on
    // both sides plus the long stall stays well under a millisecond.
    initial begin : watchdog
        #3_000_000;
        $display("grid_strip_index_generator_test NOT OK");
        $finish;
    end

endmodule

[filelist.f]
design/gsig_pkg.sv
design/gsig_core.sv
design/grid_strip_index_generator.sv
design/gsig_checker.sv
verif/grid_strip_index_checker.sv
verif/grid_strip_index_generator_test.sv
